// File: rtl/core/ilt_pkg.sv
// Shared types, codes and helpers for the IRC line tokenizer.
`default_nettype none
package ilt_pkg;

    localparam int HOLD_DEPTH_DEF = 32;
    localparam int MAX_PARAMS_DEF = 15;

    // op queue between front and back, power of two
    localparam int QDEPTH = 4;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_PARAM = 2'd1;
    localparam logic [1:0] KIND_TRAIL = 2'd2;
    localparam logic [1:0] KIND_SUM   = 2'd3;

    localparam logic [1:0] OP_EMIT  = 2'd0;
    localparam logic [1:0] OP_HOLD  = 2'd1;
    localparam logic [1:0] OP_TRAIL = 2'd2;
    localparam logic [1:0] OP_SUM   = 2'd3;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_line;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [3:0] param_index;
        logic       token_first;
        logic       has_trailing;
        logic [3:0] param_count;
        logic       has_command;
        logic       params_overflow;
        logic       hold_overflow;
        logic       last_of_run;
    } res_t;

    typedef struct packed {
        logic [1:0] op;
        res_t       res;
    } entry_t;

    typedef struct packed {
        logic   v0;
        entry_t e0;
        logic   v1;
        entry_t e1;
    } push_t;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_OFS : c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/ilt_front.sv
// Front end: per-byte line state machine, turns items into back-end ops.
`default_nettype none
module ilt_front #(
    parameter int HOLD_DEPTH = ilt_pkg::HOLD_DEPTH_DEF,
    parameter int MAX_PARAMS = ilt_pkg::MAX_PARAMS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ilt_pkg::in_t  s_data,
    input  wire logic          q_room,
    output ilt_pkg::push_t     push
);

    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam logic [3:0] MAXP = 4'(MAX_PARAMS);
    localparam logic [CNT_W-1:0] HOLD_MAX = CNT_W'(HOLD_DEPTH);

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_PREFIX = 3'd1;
    localparam logic [2:0] PH_LEAD2  = 3'd2;
    localparam logic [2:0] PH_GAP0   = 3'd3;
    localparam logic [2:0] PH_CMD    = 3'd4;
    localparam logic [2:0] PH_GAP    = 3'd5;
    localparam logic [2:0] PH_PARAM  = 3'd6;
    localparam logic [2:0] PH_TRAIL  = 3'd7;

    logic [2:0]       phase_reg, phase_next;
    logic             pws_reg, pws_next;
    logic             cmd_reg, cmd_next;
    logic [3:0]       pcnt_reg, pcnt_next;
    logic             trail_reg, trail_next;
    logic [CNT_W-1:0] hcnt_reg, hcnt_next;
    logic [1:0]       ovf_reg, ovf_next;

    logic             accept;
    logic             byte_v;
    ilt_pkg::entry_t  byte_op;
    ilt_pkg::entry_t  sum_op;
    logic [7:0]       c;
    logic             sp_tab;
    logic             sep;
    logic             colon;

    function automatic ilt_pkg::entry_t mk(input logic [1:0] op, input logic [7:0] b,
                                           input logic [1:0] kind, input logic [3:0] idx,
                                           input logic first);
        ilt_pkg::entry_t e;
        e = '0;
        e.op = op;
        e.res.out_byte = b;
        e.res.kind = kind;
        e.res.param_index = idx;
        e.res.token_first = first;
        return e;
    endfunction

    assign s_ready = q_room;
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_next = phase_reg;
        pws_next   = pws_reg;
        cmd_next   = cmd_reg;
        pcnt_next  = pcnt_reg;
        trail_next = trail_reg;
        hcnt_next  = hcnt_reg;
        ovf_next   = ovf_reg;
        byte_v     = 1'b0;
        byte_op    = '0;
        sum_op     = '0;
        push       = '0;
        c      = s_data.data_byte;
        sp_tab = (c == ilt_pkg::CH_SPACE) || (c == ilt_pkg::CH_TAB);
        sep    = ilt_pkg::is_sep(c);
        colon  = (c == ilt_pkg::CH_COLON);

        if (s_data.has_byte) begin
            case (phase_reg)
                PH_LEAD, PH_LEAD2: begin
                    if (sp_tab) begin
                        phase_next = phase_reg;
                    end else if (colon && phase_reg == PH_LEAD) begin
                        phase_next = PH_PREFIX;
                    end else if (sep) begin
                        phase_next = PH_GAP0;
                        pws_next   = 1'b0;
                    end else begin
                        byte_v  = 1'b1;
                        byte_op = mk(ilt_pkg::OP_EMIT, ilt_pkg::to_upper(c),
                                     ilt_pkg::KIND_CMD, 4'd0, 1'b1);
                        cmd_next   = 1'b1;
                        phase_next = PH_CMD;
                    end
                end
                PH_PREFIX: begin
                    if (c == ilt_pkg::CH_SPACE) begin
                        phase_next = PH_LEAD2;
                    end
                end
                PH_GAP0: begin
                    if (colon && pws_reg) begin
                        trail_next = 1'b1;
                        phase_next = PH_TRAIL;
                        pws_next   = 1'b1;
                        hcnt_next  = '0;
                    end else if (sep) begin
                        pws_next = (c == ilt_pkg::CH_SPACE);
                    end else begin
                        byte_v  = 1'b1;
                        byte_op = mk(ilt_pkg::OP_EMIT, ilt_pkg::to_upper(c),
                                     ilt_pkg::KIND_CMD, 4'd0, 1'b1);
                        cmd_next   = 1'b1;
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD: begin
                    if (sep) begin
                        phase_next = PH_GAP;
                        pws_next   = (c == ilt_pkg::CH_SPACE);
                    end else begin
                        byte_v  = 1'b1;
                        byte_op = mk(ilt_pkg::OP_EMIT, ilt_pkg::to_upper(c),
                                     ilt_pkg::KIND_CMD, 4'd0, 1'b0);
                    end
                end
                PH_GAP: begin
                    if (colon && pws_reg) begin
                        trail_next = 1'b1;
                        phase_next = PH_TRAIL;
                        pws_next   = 1'b1;
                        hcnt_next  = '0;
                    end else if (sep) begin
                        pws_next = (c == ilt_pkg::CH_SPACE);
                    end else begin
                        byte_v = 1'b1;
                        if (pcnt_reg < MAXP) begin
                            byte_op = mk(ilt_pkg::OP_EMIT, c, ilt_pkg::KIND_PARAM,
                                         pcnt_reg, 1'b1);
                            pcnt_next = pcnt_reg + 4'd1;
                        end else begin
                            byte_op = mk(ilt_pkg::OP_EMIT, c, ilt_pkg::KIND_PARAM,
                                         MAXP, 1'b1);
                            ovf_next[0] = 1'b1;
                        end
                        phase_next = PH_PARAM;
                    end
                end
                PH_PARAM: begin
                    if (sep) begin
                        phase_next = PH_GAP;
                        pws_next   = (c == ilt_pkg::CH_SPACE);
                    end else begin
                        byte_v  = 1'b1;
                        byte_op = mk(ilt_pkg::OP_EMIT, c, ilt_pkg::KIND_PARAM,
                                     ovf_reg[0] ? MAXP
                                     : (pcnt_reg != 4'd0 ? pcnt_reg - 4'd1 : 4'd0),
                                     1'b0);
                    end
                end
                default: begin
                    if (sp_tab) begin
                        if (hcnt_reg < HOLD_MAX) begin
                            byte_v    = 1'b1;
                            byte_op   = mk(ilt_pkg::OP_HOLD, c, ilt_pkg::KIND_TRAIL,
                                           4'd0, 1'b0);
                            hcnt_next = hcnt_reg + CNT_W'(1);
                        end else begin
                            ovf_next[1] = 1'b1;
                        end
                    end else begin
                        byte_v    = 1'b1;
                        byte_op   = mk(ilt_pkg::OP_TRAIL, c, ilt_pkg::KIND_TRAIL,
                                       4'd0, pws_reg);
                        hcnt_next = '0;
                        pws_next  = 1'b0;
                    end
                end
            endcase
        end

        byte_op.res.last_of_run = !s_data.end_of_line;

        sum_op.op                  = ilt_pkg::OP_SUM;
        sum_op.res.kind            = ilt_pkg::KIND_SUM;
        sum_op.res.has_trailing    = trail_next;
        sum_op.res.param_count     = pcnt_next;
        sum_op.res.has_command     = cmd_next;
        sum_op.res.params_overflow = ovf_next[0];
        sum_op.res.hold_overflow   = ovf_next[1];
        sum_op.res.last_of_run     = 1'b1;

        if (s_data.end_of_line) begin
            phase_next = PH_LEAD;
            pws_next   = 1'b0;
            cmd_next   = 1'b0;
            pcnt_next  = 4'd0;
            trail_next = 1'b0;
            hcnt_next  = '0;
            ovf_next   = 2'b00;
        end

        if (byte_v) begin
            push.v0 = accept;
            push.e0 = byte_op;
            push.v1 = accept && s_data.end_of_line;
            push.e1 = sum_op;
        end else begin
            push.v0 = accept && s_data.end_of_line;
            push.e0 = sum_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            pws_reg   <= 1'b0;
            cmd_reg   <= 1'b0;
            pcnt_reg  <= 4'd0;
            trail_reg <= 1'b0;
            hcnt_reg  <= '0;
            ovf_reg   <= 2'b00;
        end else if (accept) begin
            phase_reg <= phase_next;
            pws_reg   <= pws_next;
            cmd_reg   <= cmd_next;
            pcnt_reg  <= pcnt_next;
            trail_reg <= trail_next;
            hcnt_reg  <= hcnt_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/ilt_queue.sv
// Short op queue between front and back; takes up to two ops per cycle.
`default_nettype none
module ilt_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire ilt_pkg::push_t  push,
    output logic                 room,
    output logic                 head_valid,
    output ilt_pkg::entry_t      head,
    input  wire logic            pop
);

    localparam int PTR_W = $clog2(ilt_pkg::QDEPTH);
    localparam int CNT_W = $clog2(ilt_pkg::QDEPTH + 1);

    ilt_pkg::entry_t  mem [ilt_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]       n_push;

    assign n_push     = {1'b0, push.v0} + {1'b0, push.v1};
    assign room       = cnt_reg <= CNT_W'(ilt_pkg::QDEPTH - 2);
    assign head_valid = cnt_reg != '0;
    assign head       = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem[wr_reg] <= push.e0;
        end
        if (push.v1) begin
            mem[wr_reg + PTR_W'(1)] <= push.e1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + PTR_W'(n_push);
            rd_reg  <= rd_reg + PTR_W'(pop);
            cnt_reg <= cnt_reg + CNT_W'(n_push) - CNT_W'(pop);
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/ilt_back.sv
// Back end: executes ops, owns the trailing whitespace hold store and output register.
`default_nettype none
module ilt_back #(
    parameter int HOLD_DEPTH = ilt_pkg::HOLD_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             head_valid,
    input  wire ilt_pkg::entry_t  head,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ilt_pkg::res_t         m_data
);

    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FLUSH = 2'd1;
    localparam logic [1:0] S_BYTE  = 2'd2;

    logic             hold_mem [HOLD_DEPTH];
    logic             rd_q;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] wr_ptr_reg, wr_ptr_next;
    ilt_pkg::res_t    pend_reg, pend_next;
    ilt_pkg::res_t    out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic             advance;
    logic             load;
    logic             mem_we;

    assign advance = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next  = state_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        pend_next   = pend_reg;
        out_next    = out_reg;
        pop         = 1'b0;
        load        = 1'b0;
        mem_we      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                rd_ptr_next = '0;
                if (head_valid) begin
                    case (head.op)
                        ilt_pkg::OP_EMIT: begin
                            if (advance) begin
                                pop      = 1'b1;
                                load     = 1'b1;
                                out_next = head.res;
                            end
                        end
                        ilt_pkg::OP_SUM: begin
                            if (advance) begin
                                pop         = 1'b1;
                                load        = 1'b1;
                                out_next    = head.res;
                                wr_ptr_next = '0;
                            end
                        end
                        ilt_pkg::OP_HOLD: begin
                            pop         = 1'b1;
                            mem_we      = 1'b1;
                            wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                        end
                        default: begin
                            pop        = 1'b1;
                            pend_next  = head.res;
                            state_next = (wr_ptr_reg == '0) ? S_BYTE : S_FLUSH;
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                if (advance) begin
                    load     = 1'b1;
                    out_next = pend_reg;
                    out_next.out_byte    = rd_q ? ilt_pkg::CH_TAB : ilt_pkg::CH_SPACE;
                    out_next.last_of_run = 1'b0;
                    pend_next.token_first = 1'b0;
                    if (rd_ptr_reg + CNT_W'(1) == wr_ptr_reg) begin
                        state_next = S_BYTE;
                    end else begin
                        rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                    end
                end
            end
            S_BYTE: begin
                if (advance) begin
                    load        = 1'b1;
                    out_next    = pend_reg;
                    wr_ptr_next = '0;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hold_mem[wr_ptr_reg[IDX_W-1:0]] <= (head.res.out_byte == ilt_pkg::CH_TAB);
        end
        rd_q <= hold_mem[rd_ptr_next[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/irc_line_tokenizer_top.sv
// Top level of the IRC line tokenizer: front end, op queue, back end.
// Output: a trailing byte follows one result per held space or tab flushed ahead of it.
// Throughput: one item per cycle while the four-entry op queue has room for two ops;
// one result per cycle out while m_ready is high; a held space or tab is stored with no
// result, and a trailing byte also passes through the back end's flush and byte states.
// Reset: synchronous aresetn clears line state, queue and output; hold store is not cleared.
`default_nettype none
module irc_line_tokenizer_top #(
    parameter int HOLD_DEPTH = ilt_pkg::HOLD_DEPTH_DEF,
    parameter int MAX_PARAMS = ilt_pkg::MAX_PARAMS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire ilt_pkg::in_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output ilt_pkg::res_t       m_data
);

    ilt_pkg::push_t  push;
    ilt_pkg::entry_t head;
    logic            q_room;
    logic            head_valid;
    logic            pop;

    ilt_front #(
        .HOLD_DEPTH(HOLD_DEPTH),
        .MAX_PARAMS(MAX_PARAMS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_room  (q_room),
        .push    (push)
    );

    ilt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .room       (q_room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    ilt_back #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    a_sum_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == ilt_pkg::KIND_SUM |-> m_data.last_of_run)
        else $error("summary item not last of run");

    a_byte_no_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != ilt_pkg::KIND_SUM |->
            !m_data.has_trailing && m_data.param_count == 4'd0 && !m_data.has_command
            && !m_data.params_overflow && !m_data.hold_overflow)
        else $error("summary fields set on byte item");

    a_index_param_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != ilt_pkg::KIND_PARAM |-> m_data.param_index == 4'd0)
        else $error("param index outside middle parameter");

    a_pop_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule
`default_nettype wire
